[hdl/svsrp_pkg.sv]
// Shared types and constants for the servo status reply parser.
// Used by every module of the block; depends on nothing else.
package svsrp_pkg;

    localparam int unsigned PARAM_DEPTH = 14;
    localparam int unsigned PIDX_W      = 4;

    localparam logic [7:0]  MARKER         = 8'hFF;
    localparam logic [3:0]  PARAM_LIMIT    = 4'd14;
    localparam logic [15:0] TIMEOUT_RST    = 16'd4000;
    localparam logic [3:0]  MAX_PARAMS_RST = 4'd4;

    // item opcodes
    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // reply outcomes
    localparam logic [2:0] OUT_OK        = 3'd0;
    localparam logic [2:0] OUT_TIMEOUT   = 3'd1;
    localparam logic [2:0] OUT_NO_HEADER = 3'd2;
    localparam logic [2:0] OUT_BAD_LEN   = 3'd3;
    localparam logic [2:0] OUT_CHECKSUM  = 3'd4;

    // configuration register indexes
    localparam logic CFG_TIMEOUT    = 1'b0;
    localparam logic CFG_MAX_PARAMS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        RP_IDLE,
        RP_SINGLE,
        RP_READ,
        RP_LOAD
    } rpt_state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] servo_id;
        logic [7:0] servo_error;
        logic [3:0] param_count;
        logic [3:0] param_index;
        logic [7:0] param_byte;
        logic       last;
    } rpt_t;

    // finished reply handed from the parser to the reporter
    typedef struct packed {
        logic       valid;
        logic [2:0] outcome;
        logic [7:0] servo_id;
        logic [7:0] servo_error;
        logic [3:0] count;
    } launch_t;

endpackage

[hdl/svsrp_param_ram.sv]
// Parameter byte store: one write port, one registered read port.
// Depends on svsrp_pkg for depth and index width.
module svsrp_param_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [svsrp_pkg::PIDX_W-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [svsrp_pkg::PIDX_W-1:0] raddr,
    output logic [7:0]                   rdata
);

    logic [7:0] mem [svsrp_pkg::PARAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/svsrp_reporter.sv]
// Result sequencer: turns one finished reply into result items, reading
// parameter bytes from the store. Depends on svsrp_pkg.
module svsrp_reporter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  svsrp_pkg::launch_t           launch,
    output logic                         idle,
    output logic                         ram_re,
    output logic [svsrp_pkg::PIDX_W-1:0] ram_raddr,
    input  logic [7:0]                   ram_rdata,
    output logic                         rpt_valid,
    input  logic                         rpt_ready,
    output svsrp_pkg::rpt_t              rpt
);

    svsrp_pkg::rpt_state_t state_reg, state_next;
    logic [2:0]            outcome_reg, outcome_next;
    logic [7:0]            id_reg, id_next;
    logic [7:0]            err_reg, err_next;
    logic [3:0]            count_reg, count_next;
    logic [3:0]            idx_reg, idx_next;
    logic                  rpt_valid_reg, rpt_valid_next;
    svsrp_pkg::rpt_t       rpt_reg, rpt_next;

    logic slot_free;
    logic load_single;
    logic load_param;
    logic last_param;
    logic take;

    assign slot_free  = !rpt_valid_reg || rpt_ready;
    assign last_param = (4'(idx_reg + 4'd1) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            svsrp_pkg::RP_IDLE:
            begin
                if (launch.valid)
                begin
                    if (launch.outcome == svsrp_pkg::OUT_OK && launch.count != 4'd0)
                    begin
                        state_next = svsrp_pkg::RP_READ;
                    end
                    else
                    begin
                        state_next = svsrp_pkg::RP_SINGLE;
                    end
                end
            end
            svsrp_pkg::RP_SINGLE:
            begin
                if (slot_free)
                begin
                    state_next = svsrp_pkg::RP_IDLE;
                end
            end
            svsrp_pkg::RP_READ:
            begin
                state_next = svsrp_pkg::RP_LOAD;
            end
            svsrp_pkg::RP_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = last_param ? svsrp_pkg::RP_IDLE : svsrp_pkg::RP_READ;
                end
            end
            default:
            begin
                state_next = svsrp_pkg::RP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle        = (state_reg == svsrp_pkg::RP_IDLE);
        take        = idle && launch.valid;
        ram_re      = (state_reg == svsrp_pkg::RP_READ);
        ram_raddr   = idx_reg;
        load_single = (state_reg == svsrp_pkg::RP_SINGLE) && slot_free;
        load_param  = (state_reg == svsrp_pkg::RP_LOAD) && slot_free;
    end

    always_comb
    begin
        outcome_next   = outcome_reg;
        id_next        = id_reg;
        err_next       = err_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rpt_next       = rpt_reg;
        rpt_valid_next = rpt_valid_reg && !rpt_ready;

        if (take)
        begin
            outcome_next = launch.outcome;
            id_next      = launch.servo_id;
            err_next     = launch.servo_error;
            count_next   = launch.count;
            idx_next     = 4'd0;
        end

        if (load_single)
        begin
            rpt_next.outcome     = outcome_reg;
            rpt_next.servo_id    = id_reg;
            rpt_next.servo_error = err_reg;
            rpt_next.param_count = count_reg;
            rpt_next.param_index = 4'd0;
            rpt_next.param_byte  = 8'd0;
            rpt_next.last        = 1'b1;
            rpt_valid_next       = 1'b1;
        end
        else if (load_param)
        begin
            rpt_next.outcome     = outcome_reg;
            rpt_next.servo_id    = id_reg;
            rpt_next.servo_error = err_reg;
            rpt_next.param_count = count_reg;
            rpt_next.param_index = idx_reg;
            rpt_next.param_byte  = ram_rdata;
            rpt_next.last        = last_param;
            rpt_valid_next       = 1'b1;
            idx_next             = 4'(idx_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svsrp_pkg::RP_IDLE;
            rpt_valid_reg <= 1'b0;
            count_reg     <= 4'd0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rpt_valid_reg <= rpt_valid_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        id_reg      <= id_next;
        err_reg     <= err_next;
        rpt_reg     <= rpt_next;
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

    a_read_has_params: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == svsrp_pkg::RP_READ) |-> (count_reg != 4'd0))
        else $error("parameter read with empty count");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == svsrp_pkg::RP_LOAD) |-> (idx_reg < count_reg))
        else $error("parameter index past count");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load_param && last_param) |=> (state_reg == svsrp_pkg::RP_IDLE && rpt_valid_reg))
        else $error("last parameter did not end the reply");

endmodule

[hdl/servo_status_reply_parser_core.sv]
// Servo status reply parser. An arm item starts a reply wait; byte items
// are hunted for two 0xFF markers within SYNC_LIMIT bytes, then id, length,
// error byte, parameters and an inverted-sum checksum are taken; tick items
// time out the wait after the configured number of ticks without a byte.
// Arm, byte and tick items are taken only while the result sequencer is
// idle. A finished reply yields one result item for a failure or a reply
// without parameters, otherwise one item per handed-out parameter; each
// parameter byte is read from the registered parameter store and then loaded
// into the output register, and the input holds off until the last result
// item has been loaded. The final result may wait in the output register
// while new items are taken. Parameter storage needs no clearing after reset.
// Depends on svsrp_pkg, svsrp_param_ram and svsrp_reporter.
module servo_status_reply_parser_core #(
    parameter int unsigned MAX_BODY   = 16,
    parameter int unsigned SYNC_LIMIT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  svsrp_pkg::cmd_t   cmd,
    output logic              rpt_valid,
    input  logic              rpt_ready,
    output svsrp_pkg::rpt_t   rpt,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata
);

    localparam int unsigned HC_W  = $clog2(SYNC_LIMIT + 1);
    localparam int unsigned LEN_W = $clog2(MAX_BODY + 1);
    localparam int unsigned BP_W  = $clog2(MAX_BODY);

    svsrp_pkg::phase_t phase_reg, phase_next;
    logic              prev_marker_reg, prev_marker_next;
    logic [HC_W-1:0]   hunt_count_reg, hunt_count_next;
    logic [7:0]        reply_id_reg, reply_id_next;
    logic [LEN_W-1:0]  reply_len_reg, reply_len_next;
    logic [7:0]        error_reg, error_next;
    logic [BP_W-1:0]   body_pos_reg, body_pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic [15:0]       wait_ticks_reg, wait_ticks_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic [3:0]        max_params_reg, max_params_next;

    svsrp_pkg::launch_t launch;
    logic               rep_idle;
    logic               ram_we;
    logic [3:0]         ram_waddr;
    logic               ram_re;
    logic [3:0]         ram_raddr;
    logic [7:0]         ram_rdata;

    logic        fire;
    logic        active;
    logic        op_arm;
    logic        op_byte;
    logic        op_tick;
    logic [7:0]  b;
    logic [HC_W-1:0] hunt_inc;
    logic        hunt_done;
    logic        hunt_over;
    logic        len_bad;
    logic [7:0]  pos8;
    logic        body_end;
    logic        sum_ok;
    logic [15:0] ticks_inc;
    logic        tick_fail;
    logic [7:0]  nparams;
    logic [3:0]  lim;
    logic [3:0]  count;

    assign cmd_ready = rep_idle;
    assign fire      = cmd_valid && cmd_ready;
    assign active    = (phase_reg != svsrp_pkg::PH_IDLE);
    assign b         = cmd.data_byte;
    assign op_arm    = fire && (cmd.opcode == svsrp_pkg::OP_ARM);
    assign op_byte   = fire && active && (cmd.opcode == svsrp_pkg::OP_BYTE);
    assign op_tick   = fire && active && (cmd.opcode == svsrp_pkg::OP_TICK);

    assign hunt_inc  = HC_W'(hunt_count_reg + 1'b1);
    assign hunt_done = prev_marker_reg && (b == svsrp_pkg::MARKER);
    assign hunt_over = (hunt_inc >= HC_W'(SYNC_LIMIT));
    assign len_bad   = (b < 8'd2) || (b > 8'(MAX_BODY));
    assign pos8      = 8'(body_pos_reg);
    assign body_end  = (8'(pos8 + 8'd1) >= 8'(reply_len_reg));
    assign sum_ok    = (~sum_reg == b);
    assign ticks_inc = (wait_ticks_reg == 16'hFFFF) ? wait_ticks_reg
                                                    : 16'(wait_ticks_reg + 16'd1);
    assign tick_fail = (ticks_inc >= timeout_reg);

    // parameters handed out: min(length - 2, min(max_params, 14))
    assign nparams = 8'(8'(reply_len_reg) - 8'd2);
    assign lim     = (max_params_reg > svsrp_pkg::PARAM_LIMIT) ? svsrp_pkg::PARAM_LIMIT
                                                               : max_params_reg;
    assign count   = (nparams < {4'd0, lim}) ? nparams[3:0] : lim;

    // finished replies
    always_comb
    begin
        launch = '0;
        if (op_byte)
        begin
            case (phase_reg)
                svsrp_pkg::PH_HUNT:
                begin
                    if (!hunt_done && hunt_over)
                    begin
                        launch.valid   = 1'b1;
                        launch.outcome = svsrp_pkg::OUT_NO_HEADER;
                    end
                end
                svsrp_pkg::PH_LEN:
                begin
                    if (len_bad)
                    begin
                        launch.valid   = 1'b1;
                        launch.outcome = svsrp_pkg::OUT_BAD_LEN;
                    end
                end
                svsrp_pkg::PH_BODY:
                begin
                    if (body_end)
                    begin
                        launch.valid = 1'b1;
                        if (sum_ok)
                        begin
                            launch.outcome     = svsrp_pkg::OUT_OK;
                            launch.servo_id    = reply_id_reg;
                            launch.servo_error = error_reg;
                            launch.count       = count;
                        end
                        else
                        begin
                            launch.outcome = svsrp_pkg::OUT_CHECKSUM;
                        end
                    end
                end
                default:
                begin
                    launch = '0;
                end
            endcase
        end
        else if (op_tick && tick_fail)
        begin
            launch.valid   = 1'b1;
            launch.outcome = svsrp_pkg::OUT_TIMEOUT;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (op_arm)
        begin
            phase_next = svsrp_pkg::PH_HUNT;
        end
        else if (launch.valid)
        begin
            phase_next = svsrp_pkg::PH_IDLE;
        end
        else if (op_byte)
        begin
            case (phase_reg)
                svsrp_pkg::PH_HUNT:
                begin
                    if (hunt_done)
                    begin
                        phase_next = svsrp_pkg::PH_ID;
                    end
                end
                svsrp_pkg::PH_ID:
                begin
                    phase_next = svsrp_pkg::PH_LEN;
                end
                svsrp_pkg::PH_LEN:
                begin
                    phase_next = svsrp_pkg::PH_BODY;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        prev_marker_next = prev_marker_reg;
        hunt_count_next  = hunt_count_reg;
        reply_id_next    = reply_id_reg;
        reply_len_next   = reply_len_reg;
        error_next       = error_reg;
        body_pos_next    = body_pos_reg;
        sum_next         = sum_reg;
        wait_ticks_next  = wait_ticks_reg;
        timeout_next     = timeout_reg;
        max_params_next  = max_params_reg;
        ram_we           = 1'b0;
        ram_waddr        = 4'(pos8 - 8'd1);

        if (cfg_we)
        begin
            case (cfg_index)
                svsrp_pkg::CFG_TIMEOUT:    timeout_next    = cfg_wdata;
                svsrp_pkg::CFG_MAX_PARAMS: max_params_next = cfg_wdata[3:0];
                default:                   timeout_next    = timeout_reg;
            endcase
        end

        if (op_arm || launch.valid)
        begin
            // drop whatever was in progress
            prev_marker_next = 1'b0;
            hunt_count_next  = '0;
            reply_id_next    = 8'd0;
            reply_len_next   = '0;
            error_next       = 8'd0;
            body_pos_next    = '0;
            sum_next         = 8'd0;
            wait_ticks_next  = 16'd0;
        end
        else if (op_byte)
        begin
            wait_ticks_next = 16'd0;
            case (phase_reg)
                svsrp_pkg::PH_HUNT:
                begin
                    hunt_count_next = hunt_inc;
                    if (!hunt_done)
                    begin
                        prev_marker_next = (b == svsrp_pkg::MARKER);
                    end
                end
                svsrp_pkg::PH_ID:
                begin
                    reply_id_next = b;
                    sum_next      = b;
                end
                svsrp_pkg::PH_LEN:
                begin
                    reply_len_next = LEN_W'(b);
                    sum_next       = 8'(sum_reg + b);
                    body_pos_next  = '0;
                end
                svsrp_pkg::PH_BODY:
                begin
                    if (pos8 == 8'd0)
                    begin
                        error_next = b;
                    end
                    else if (pos8 <= 8'(svsrp_pkg::PARAM_DEPTH))
                    begin
                        ram_we = 1'b1;
                    end
                    sum_next      = 8'(sum_reg + b);
                    body_pos_next = BP_W'(body_pos_reg + 1'b1);
                end
                default:
                begin
                    wait_ticks_next = 16'd0;
                end
            endcase
        end
        else if (op_tick)
        begin
            wait_ticks_next = ticks_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= svsrp_pkg::PH_IDLE;
            prev_marker_reg <= 1'b0;
            hunt_count_reg  <= '0;
            reply_id_reg    <= 8'd0;
            reply_len_reg   <= '0;
            error_reg       <= 8'd0;
            body_pos_reg    <= '0;
            sum_reg         <= 8'd0;
            wait_ticks_reg  <= 16'd0;
            timeout_reg     <= svsrp_pkg::TIMEOUT_RST;
            max_params_reg  <= svsrp_pkg::MAX_PARAMS_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            prev_marker_reg <= prev_marker_next;
            hunt_count_reg  <= hunt_count_next;
            reply_id_reg    <= reply_id_next;
            reply_len_reg   <= reply_len_next;
            error_reg       <= error_next;
            body_pos_reg    <= body_pos_next;
            sum_reg         <= sum_next;
            wait_ticks_reg  <= wait_ticks_next;
            timeout_reg     <= timeout_next;
            max_params_reg  <= max_params_next;
        end
    end

    svsrp_param_ram u_param_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (b),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    svsrp_reporter u_reporter (
        .clk       (clk),
        .rst_n     (rst_n),
        .launch    (launch),
        .idle      (rep_idle),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt)
    );

    a_no_write_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> rep_idle)
        else $error("parameter store written while results are read");

    a_body_length_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == svsrp_pkg::PH_BODY) |-> (reply_len_reg >= LEN_W'(2)))
        else $error("body phase with short length");

    a_idle_after_reply: assert property (@(posedge clk) disable iff (!rst_n)
        launch.valid |=> (phase_reg == svsrp_pkg::PH_IDLE))
        else $error("parser not idle after a finished reply");

endmodule
